### sv/bpe_pkg.sv
// Package for the bitfield password encoder: sizes, generator constants,
// the insertion slots and the output alphabet. No dependencies.
`timescale 1ns / 1ps
package bpe_pkg;
  localparam int unsigned DataBits = 55;
  localparam int unsigned ShuffleRounds = 4;
  localparam int unsigned ValBits = 66;
  localparam int unsigned SymCount = 12;
  localparam logic [31:0] LcgMul = 32'd2100005341;
  localparam logic [31:0] LcgAdd = 32'd3321;
  localparam logic [31:0] LcgBase = 32'h43456345;
  localparam logic [15:0] CrcPoly = 16'h8408;

  typedef enum logic [3:0] {
    StIdle, StMask1, StMask2, StFill, StCheck, StCrc, StInit, StDraw, StMod,
    StSwap, StScat, StEmit, StOut
  } state_e;

  function automatic logic seed_slot(input logic [6:0] k);
    return (k == 7'd6) || (k == 7'd16) || (k == 7'd21) || (k == 7'd24) ||
           (k == 7'd46) || (k == 7'd59);
  endfunction

  function automatic logic [6:0] alpha(input logic [5:0] s);
    logic [7:0] tab [64];
    tab = '{8'h21, 8'h24, 8'h25, 8'h26, 8'h2a, 8'h2b, 8'h2d, 8'h3a, 8'h30, 8'h31,
            8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3c, 8'h3d,
            8'h3e, 8'h3f, 8'h40, 8'h41, 8'h5a, 8'h43, 8'h45, 8'h46, 8'h47, 8'h48,
            8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h50, 8'h51, 8'h52, 8'h54, 8'h55,
            8'h56, 8'h57, 8'h58, 8'h59, 8'h5b, 8'h5d, 8'h5e, 8'h61, 8'h62, 8'h64,
            8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6d, 8'h6e, 8'h71,
            8'h72, 8'h74, 8'h79, 8'h7a};
    return tab[s][6:0];
  endfunction
endpackage

### sv/bpe_lcg.sv
// Linear congruential generator with one registered multiply per step.
// Depends on bpe_pkg.
`timescale 1ns / 1ps
module bpe_lcg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [5:0]  seed_i,
  input  logic        step_i,
  output logic [15:0] draw_o
);
  logic [31:0] state_q, state_d;
  always_comb begin
    state_d = state_q;
    if (load_i) state_d = {26'd0, seed_i} + bpe_pkg::LcgBase;
    else if (step_i) state_d = bpe_pkg::LcgMul * state_q + bpe_pkg::LcgAdd;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= 32'd1;
    else state_q <= state_d;
  end
  assign draw_o = state_q[31:16];
endmodule

### sv/bpe_mod66.sv
// Serial restoring reduction of a 16-bit draw modulo 66, one bit a cycle.
// Depends on bpe_pkg.
`timescale 1ns / 1ps
module bpe_mod66 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] draw_i,
  output logic        done_o,
  output logic [6:0]  rem_o
);
  logic [15:0] sh_q, sh_d;
  logic [6:0] rem_q, rem_d;
  logic [4:0] cnt_q, cnt_d;
  logic [7:0] t;
  always_comb begin
    sh_d = sh_q; rem_d = rem_q; cnt_d = cnt_q;
    t = {rem_q, sh_q[15]};
    if (start_i) begin
      sh_d = draw_i; rem_d = '0; cnt_d = 5'd16;
    end else if (cnt_q != 5'd0) begin
      rem_d = (t >= 8'(bpe_pkg::ValBits)) ? 7'(t - 8'(bpe_pkg::ValBits)) : t[6:0];
      sh_d = {sh_q[14:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sh_q <= '0; rem_q <= '0;
    end else begin
      cnt_q <= cnt_d; sh_q <= sh_d; rem_q <= rem_d;
    end
  end
  assign done_o = (cnt_q == 5'd0) && !start_i;
  assign rem_o = rem_q;
endmodule

### sv/bitfield_password_encoder.sv
// Top level of the bitfield password encoder: field serializer, checksums,
// shuffle sequencer and symbol output. Depends on bpe_pkg, bpe_lcg, bpe_mod66.
//
// Input items are fields (data_value_i, field_length_i, seed_i, last_field_i),
// taken while in_stall_o is low. Each field is shifted in one bit per cycle;
// the first field of a message first makes the two mask draws. A last field
// then runs the checksum, the CRC, the table fill, 264 shuffle steps (each
// waits on the serial modulo unit), the scatter and the symbol assembly.
// Twelve result items follow; one is offered at a time from an output
// register and holds while out_stall_i is high. Reset clears the message
// state and all control.
// The permutation table is read into registers before each swap or scatter
// step. Data places at or above the bit count read as zero; the checksum
// and CRC places above them read from the buffer.
`timescale 1ns / 1ps
module bitfield_password_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_value_i,
  input  logic [5:0]  field_length_i,
  input  logic [5:0]  seed_i,
  input  logic        last_field_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  char_code_o,
  output logic        last_char_o,
  output logic        length_error_o
);
  bpe_pkg::state_e st_q, st_d;
  logic [65:0] buf_q;
  logic [6:0] perm_q [66];
  logic [6:0] cnt_q, k_q, ob_q, t_q, tmp_q, pk_q;
  logic [5:0] len_q, seed_q;
  logic [2:0] sp_q, nb_q, rnd_q;
  logic [31:0] val_q, mask_q;
  logic [15:0] d1_q, crc_q;
  logic [7:0] acc_q, chunk_q;
  logic [3:0] cpos_q;
  logic [5:0] sym_q;
  logic [3:0] u_q;
  logic open_q, ovf_q, fin_q, err_q, ph_q;
  logic [65:0] mix_q;
  logic lcg_load, lcg_step, mod_start, mod_done;
  logic [15:0] draw;
  logic [6:0] rem;
  logic take_in, bit_in, buf_rd;
  logic [7:0] chk_n;
  logic [15:0] crc_step, crc_fin;
  logic [5:0] fold6;

  bpe_lcg u_lcg (.clk_i, .rst_ni, .load_i(lcg_load), .seed_i(seed_q),
    .step_i(lcg_step), .draw_o(draw));
  bpe_mod66 u_mod (.clk_i, .rst_ni, .start_i(mod_start), .draw_i(draw),
    .done_o(mod_done), .rem_o(rem));

  assign take_in = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != bpe_pkg::StIdle);
  assign bit_in = (len_q > 6'd32) ? 1'b0 : val_q[5'(len_q - 6'd1)];
  assign buf_rd = (k_q < cnt_q || k_q >= 7'(bpe_pkg::DataBits)) ? buf_q[k_q] : 1'b0;
  assign chk_n = acc_q + {3'd0, chunk_q[2:0], buf_rd, 1'b0} + {3'd0, chunk_q[6:3], 1'b0};
  assign crc_step = crc_q[0] ? ((crc_q >> 1) ^ bpe_pkg::CrcPoly) : (crc_q >> 1);
  assign crc_fin = crc_step ^ 16'hFFFF;
  assign fold6 = crc_fin[13:8] ^ crc_fin[5:0];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      bpe_pkg::StIdle: if (take_in) st_d = open_q ? bpe_pkg::StFill : bpe_pkg::StMask1;
      bpe_pkg::StMask1: if (ph_q) st_d = bpe_pkg::StMask2;
      bpe_pkg::StMask2: if (ph_q) st_d = bpe_pkg::StFill;
      bpe_pkg::StFill: if (len_q == 6'd0) st_d = fin_q ? bpe_pkg::StCheck : bpe_pkg::StIdle;
      bpe_pkg::StCheck: if (k_q == 7'(bpe_pkg::DataBits - 1)) st_d = bpe_pkg::StCrc;
      bpe_pkg::StCrc: if (k_q == 7'(bpe_pkg::DataBits + 4) && cpos_q == 4'd8)
        st_d = bpe_pkg::StInit;
      bpe_pkg::StInit: if (k_q == 7'(bpe_pkg::ValBits - 1)) st_d = bpe_pkg::StDraw;
      bpe_pkg::StDraw: st_d = bpe_pkg::StMod;
      bpe_pkg::StMod: if (mod_done && ph_q) st_d = bpe_pkg::StSwap;
      bpe_pkg::StSwap: if (ph_q) begin
        if (k_q == 7'(bpe_pkg::ValBits - 1) && rnd_q == 3'(bpe_pkg::ShuffleRounds - 1))
          st_d = bpe_pkg::StScat;
        else st_d = bpe_pkg::StDraw;
      end
      bpe_pkg::StScat: if (ph_q && k_q == 7'(bpe_pkg::ValBits - 1)) st_d = bpe_pkg::StEmit;
      bpe_pkg::StEmit: if (nb_q == 3'd5) st_d = bpe_pkg::StOut;
      bpe_pkg::StOut: if (!out_stall_i)
        st_d = (u_q == 4'(bpe_pkg::SymCount - 1)) ? bpe_pkg::StIdle : bpe_pkg::StEmit;
      default: st_d = bpe_pkg::StIdle;
    endcase
  end

  always_comb begin
    lcg_load = 1'b0; lcg_step = 1'b0; mod_start = 1'b0;
    unique case (st_q)
      bpe_pkg::StMask1: begin
        lcg_load = !ph_q;
        lcg_step = ph_q;
      end
      bpe_pkg::StMask2: lcg_step = !ph_q;
      bpe_pkg::StDraw: lcg_step = 1'b1;
      bpe_pkg::StMod: mod_start = !ph_q;
      default: ;
    endcase
  end

  assign out_valid_o = (st_q == bpe_pkg::StOut);
  assign char_code_o = bpe_pkg::alpha(sym_q);
  assign last_char_o = (u_q == 4'(bpe_pkg::SymCount - 1));
  assign length_error_o = err_q;

  always_ff @(posedge clk_i) begin
    if (st_q == bpe_pkg::StInit) begin
      perm_q[k_q] <= k_q;
    end else if (st_q == bpe_pkg::StSwap && ph_q) begin
      perm_q[k_q] <= tmp_q;
      if (t_q != k_q) perm_q[t_q] <= pk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bpe_pkg::StIdle;
      open_q <= 1'b0; ovf_q <= 1'b0; cnt_q <= '0; seed_q <= '0; mask_q <= '0;
      buf_q <= '0; ph_q <= 1'b0; u_q <= '0; k_q <= '0; len_q <= '0;
      val_q <= '0; fin_q <= 1'b0; d1_q <= '0; crc_q <= '0; acc_q <= '0;
      chunk_q <= '0; cpos_q <= '0; sym_q <= '0; rnd_q <= '0; t_q <= '0;
      tmp_q <= '0; pk_q <= '0; ob_q <= '0; sp_q <= '0; nb_q <= '0;
      err_q <= 1'b0; mix_q <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        bpe_pkg::StIdle: if (take_in) begin
          val_q <= open_q ? (data_value_i ^ mask_q) : data_value_i;
          len_q <= field_length_i; fin_q <= last_field_i;
          if (!open_q) seed_q <= seed_i;
          open_q <= 1'b1; ph_q <= 1'b0;
        end
        bpe_pkg::StMask1: ph_q <= !ph_q;
        bpe_pkg::StMask2: begin
          ph_q <= !ph_q;
          if (!ph_q) d1_q <= draw;
          else begin
            mask_q <= ({16'd0, d1_q} << 14) + {16'd0, draw};
            val_q <= val_q ^ (({16'd0, d1_q} << 14) + {16'd0, draw});
          end
        end
        bpe_pkg::StFill: begin
          if (ph_q == 1'b0 && st_q == bpe_pkg::StFill && open_q && len_q != 6'd0) begin
            if (cnt_q < 7'(bpe_pkg::DataBits)) begin
              buf_q[cnt_q] <= bit_in; cnt_q <= cnt_q + 7'd1;
            end else ovf_q <= 1'b1;
            len_q <= len_q - 6'd1;
          end
          if (len_q == 6'd0) begin
            k_q <= '0; acc_q <= '0; chunk_q <= '0; cpos_q <= '0; crc_q <= 16'hFFFF;
          end
        end
        bpe_pkg::StCheck: begin
          if (k_q[2:0] == 3'd7 || k_q == 7'(bpe_pkg::DataBits - 1)) begin
            acc_q <= chk_n;
            chunk_q <= '0;
          end else chunk_q <= {chunk_q[6:0], buf_rd};
          if (k_q == 7'(bpe_pkg::DataBits - 1)) begin
            buf_q[bpe_pkg::DataBits +: 5] <= {chk_n[0], chk_n[1], chk_n[2], chk_n[3], chk_n[4]};
            k_q <= '0; cpos_q <= '0;
          end else k_q <= k_q + 7'd1;
        end
        bpe_pkg::StCrc: begin
          if (cpos_q == 4'd0) begin
            if (k_q[2:0] == 3'd7 || k_q == 7'(bpe_pkg::DataBits + 4)) begin
              crc_q <= crc_q ^ {8'd0, chunk_q[6:0], buf_rd};
              chunk_q <= '0; cpos_q <= 4'd1;
            end else begin
              chunk_q <= {chunk_q[6:0], buf_rd};
              k_q <= k_q + 7'd1;
            end
          end else begin
            crc_q <= crc_step;
            if (cpos_q == 4'd8) begin
              cpos_q <= 4'd0;
              if (k_q == 7'(bpe_pkg::DataBits + 4)) begin
                k_q <= '0;
                buf_q[bpe_pkg::DataBits + 5 +: 6] <=
                  {fold6[0], fold6[1], fold6[2], fold6[3], fold6[4], fold6[5]};
              end else k_q <= k_q + 7'd1;
            end else cpos_q <= cpos_q + 4'd1;
          end
        end
        bpe_pkg::StInit: begin
          k_q <= (k_q == 7'(bpe_pkg::ValBits - 1)) ? 7'd0 : k_q + 7'd1;
          rnd_q <= '0; ph_q <= 1'b0;
        end
        bpe_pkg::StDraw: ph_q <= 1'b0;
        bpe_pkg::StMod: begin
          if (mod_done && ph_q) begin
            t_q <= rem; ph_q <= 1'b0;
          end else ph_q <= 1'b1;
        end
        bpe_pkg::StSwap: begin
          ph_q <= !ph_q;
          if (!ph_q) begin
            tmp_q <= perm_q[t_q];
            pk_q <= perm_q[k_q];
          end else begin
            if (k_q == 7'(bpe_pkg::ValBits - 1)) begin
              k_q <= '0; rnd_q <= rnd_q + 3'd1;
            end else k_q <= k_q + 7'd1;
          end
        end
        bpe_pkg::StScat: begin
          ph_q <= !ph_q;
          if (!ph_q) pk_q <= perm_q[k_q];
          else begin
            mix_q[pk_q] <= buf_rd;
            if (k_q == 7'(bpe_pkg::ValBits - 1)) begin
              k_q <= '0; ob_q <= '0; sp_q <= '0; nb_q <= '0; u_q <= '0;
              err_q <= ovf_q || (cnt_q != 7'(bpe_pkg::DataBits));
            end else k_q <= k_q + 7'd1;
          end
        end
        bpe_pkg::StEmit: begin
          if (bpe_pkg::seed_slot(k_q)) begin
            sym_q <= {sym_q[4:0], seed_q[sp_q]}; sp_q <= sp_q + 3'd1;
          end else begin
            sym_q <= {sym_q[4:0], mix_q[ob_q]}; ob_q <= ob_q + 7'd1;
          end
          k_q <= k_q + 7'd1;
          nb_q <= (nb_q == 3'd5) ? 3'd0 : nb_q + 3'd1;
        end
        bpe_pkg::StOut: if (!out_stall_i) begin
          u_q <= u_q + 4'd1;
          if (u_q == 4'(bpe_pkg::SymCount - 1)) begin
            cnt_q <= '0; open_q <= 1'b0; ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while results pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_code_o))
    else $error("stalled item changed");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(bpe_pkg::DataBits)) else $error("bit count overran");
endmodule

### bench/bitfield_password_encoder_chk.sv
// Checker for the bitfield password encoder: predicts the twelve password
// characters of each message from the accepted fields and compares them.
// Depends on bpe_pkg.
`timescale 1ns / 1ps
module bitfield_password_encoder_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] data_value_i,
  input  logic [5:0]  field_length_i,
  input  logic [5:0]  seed_i,
  input  logic        last_field_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [6:0]  char_code_i,
  input  logic        last_char_i,
  input  logic        length_error_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          pw_count_o,
  output int          err_pw_count_o
);
  typedef struct packed {
    logic [6:0] code;
    logic       last;
    logic       err;
  } pw_char_t;

  pw_char_t   char_q[$];
  logic       msg_bits[bpe_pkg::ValBits] = '{default: 1'b0};
  int         msg_count = 0;
  logic [31:0] gen_state;
  logic [31:0] field_mask;
  logic [5:0] msg_seed;
  logic       msg_open = 1'b0;
  logic       msg_over = 1'b0;
  int         fails = 0;
  int         pws = 0;
  int         err_pws = 0;

  assign fail_count_o = fails;
  assign pw_count_o = pws;
  assign err_pw_count_o = err_pws;

  function automatic logic [15:0] gen_draw();
    gen_state = gen_state * bpe_pkg::LcgMul + bpe_pkg::LcgAdd;
    return gen_state[31:16];
  endfunction

  function automatic logic [7:0] byte_at(int p, int cnt);
    logic [7:0] v;
    v = 0;
    for (int k = p; k < p + 8 && k < cnt; k++) v = {v[6:0], msg_bits[k]};
    return v;
  endfunction

  task automatic report(string what, logic [8:0] got, logic [8:0] want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic finish_message();
    logic [31:0] acc;
    logic [15:0] crc;
    logic [7:0]  fold;
    logic [7:0]  bt;
    logic [6:0]  perm[bpe_pkg::ValBits];
    logic [6:0]  t, h;
    logic        mixed[bpe_pkg::ValBits];
    logic [5:0]  sym;
    int          sp, ob, nb, u;
    logic        b, err;
    err = msg_over || msg_count != bpe_pkg::DataBits;
    acc = 0;
    for (int p = 0; p < bpe_pkg::DataBits; p += 8) begin
      bt = byte_at(p, bpe_pkg::DataBits);
      acc += 2 * (32'(bt[3:0]) + 32'(bt[7:4]));
    end
    for (int k = 0; k < 5; k++) msg_bits[bpe_pkg::DataBits + k] = acc[4 - k];
    crc = 16'hffff;
    for (int p = 0; p < bpe_pkg::DataBits + 5; p += 8) begin
      crc ^= {8'd0, byte_at(p, bpe_pkg::DataBits + 5)};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ bpe_pkg::CrcPoly) : (crc >> 1);
      end
    end
    crc ^= 16'hffff;
    fold = crc[15:8] ^ crc[7:0];
    for (int k = 0; k < 6; k++) msg_bits[bpe_pkg::DataBits + 5 + k] = fold[5 - k];
    for (int k = 0; k < bpe_pkg::ValBits; k++) perm[k] = 7'(k);
    for (int w = 0; w < bpe_pkg::ShuffleRounds; w++) begin
      for (int k = 0; k < bpe_pkg::ValBits; k++) begin
        t = 7'(32'(gen_draw()) % bpe_pkg::ValBits);
        h = perm[t];
        perm[t] = perm[k];
        perm[k] = h;
      end
    end
    for (int k = 0; k < bpe_pkg::ValBits; k++) mixed[perm[k]] = msg_bits[k];
    sp = 0; ob = 0; nb = 0; u = 0; sym = 0;
    for (int k = 0; k < bpe_pkg::ValBits + 6; k++) begin
      if (bpe_pkg::seed_slot(7'(k))) begin
        b = msg_seed[sp];
        sp++;
      end else begin
        b = (ob < bpe_pkg::ValBits) ? mixed[ob] : 1'b0;
        ob++;
      end
      sym = {sym[4:0], b};
      nb++;
      if (nb == 6) begin
        char_q.push_back('{bpe_pkg::alpha(sym), u == bpe_pkg::SymCount - 1, err});
        u++;
        nb = 0;
      end
    end
    pws++;
    if (err) err_pws++;
    for (int k = 0; k < bpe_pkg::ValBits; k++) msg_bits[k] = 0;
    msg_count = 0;
    msg_open = 0;
    msg_over = 0;
  endtask

  task automatic b_push(logic b);
    if (msg_count < bpe_pkg::DataBits) begin
      msg_bits[msg_count] = b;
      msg_count++;
    end else begin
      msg_over = 1;
    end
  endtask

  task automatic take_field();
    logic [31:0] v;
    logic [15:0] d1, d2;
    if (!msg_open) begin
      msg_seed = seed_i;
      gen_state = {26'd0, seed_i} + bpe_pkg::LcgBase;
      d1 = gen_draw();
      d2 = gen_draw();
      field_mask = ({16'd0, d1} << 14) + {16'd0, d2};
      msg_open = 1;
    end
    v = data_value_i ^ field_mask;
    for (int k = int'(field_length_i) - 1; k >= 0; k--) begin
      b_push((k < 32) ? v[k] : 1'b0);
    end
    if (last_field_i) finish_message();
  endtask

  always @(posedge clk_i) begin
    pw_char_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) take_field();
      if (out_valid_i && !out_stall_i) begin
        if (char_q.size() == 0) begin
          report("unexpected char", {char_code_i, last_char_i, length_error_i}, 9'd0);
        end else begin
          want = char_q.pop_front();
          if (char_code_i !== want.code) report("char_code", 9'(char_code_i), 9'(want.code));
          if (last_char_i !== want.last) report("last_char", 9'(last_char_i), 9'(want.last));
          if (length_error_i !== want.err) begin
            report("length_error", 9'(length_error_i), 9'(want.err));
          end
        end
      end
    end
    pending_o = char_q.size();
  end
endmodule

### bench/bitfield_password_encoder_tb.sv
// Testbench top for the bitfield password encoder: drives fields in bursts,
// stalls the output, and gives the verdict. Depends on the block and
// bitfield_password_encoder_chk.
`timescale 1ns / 1ps
module bitfield_password_encoder_tb;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [31:0] data_value_i = 0;
  logic [5:0]  field_length_i = 0;
  logic [5:0]  seed_i = 0;
  logic        last_field_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [6:0]  char_code_o;
  logic        last_char_o;
  logic        length_error_o;
  int          fail_count, pending, pw_count, err_pw_count;
  int          cycle_count = 0;
  int          field_count = 0;
  int          burst_left = 0;

  always #1 clk_i = ~clk_i;

  bitfield_password_encoder i_dut (.*);

  bitfield_password_encoder_chk i_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .data_value_i,
    .field_length_i, .seed_i, .last_field_i, .out_valid_i(out_valid_o), .out_stall_i,
    .char_code_i(char_code_o), .last_char_i(last_char_o), .length_error_i(length_error_o),
    .fail_count_o(fail_count), .pending_o(pending), .pw_count_o(pw_count),
    .err_pw_count_o(err_pw_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 6000000) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    case ((cycle_count / 97) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send(logic [31:0] v, logic [5:0] len, logic [5:0] sd, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_value_i <= v;
    field_length_i <= len;
    seed_i <= sd;
    last_field_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    field_count++;
  endtask

  task automatic send_message(logic [5:0] sd, int total, logic [31:0] fill);
    int left, len;
    left = total;
    while (left > 0) begin
      len = $urandom_range(1, (left < 32) ? left : 32);
      left -= len;
      send(fill == 0 ? $urandom : fill, 6'(len), sd, left == 0);
      sd = 6'($urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(32'hffffffff, 6'd32, 6'd0, 1'b0);
    send(32'h00000000, 6'd23, 6'd0, 1'b1);
    send(32'h00000000, 6'd32, 6'd63, 1'b0);
    send(32'hffffffff, 6'd23, 6'd0, 1'b1);
    send(32'h12345678, 6'd0, 6'd42, 1'b0);
    send(32'hdeadbeef, 6'd63, 6'd0, 1'b0);
    send(32'hcafef00d, 6'd33, 6'd0, 1'b1);
    send(32'h1, 6'd1, 6'd21, 1'b1);
    send(32'h0, 6'd0, 6'd5, 1'b1);
    send_message(6'd63, 55, 32'hffffffff);
    send_message(6'd1, 55, 32'h0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    while (field_count < 270) begin
      case ($urandom_range(0, 9))
        0: send_message(6'($urandom), $urandom_range(1, 54), 0);
        1: send_message(6'($urandom), $urandom_range(56, 90), 0);
        2: send($urandom, 6'($urandom), 6'($urandom), 1'($urandom_range(0, 1)));
        default: send_message(6'($urandom), 55, 0);
      endcase
    end
    send_message(6'($urandom), 55, 0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d fields gave %0d passwords, %0d with a length error.",
             field_count, pw_count, err_pw_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
